### sv/gkc_pkg.sv
// Shared types and constants of the glyph key cache tag store.
package gkc_pkg;

	localparam int CP_W       = 21;
	localparam int PX_W       = 10;
	localparam int HASH_W     = 32;
	localparam int SLOT_IDX_W = 8;
	localparam int ENTRY_W    = 1 + CP_W + PX_W;

	localparam logic [HASH_W-1:0] HASH_MUL_CP = 32'd2654435761;
	localparam logic [HASH_W-1:0] HASH_MUL_PX = 32'd40503;

	localparam logic ACT_LOOKUP = 1'b0;
	localparam logic ACT_FLUSH  = 1'b1;

	typedef struct packed {
		logic            action;
		logic [CP_W-1:0] code_point;
		logic [PX_W-1:0] pixel_size;
	} req_t;

	typedef struct packed {
		logic                  hit;
		logic [SLOT_IDX_W-1:0] slot_index;
		logic                  evicted;
		logic                  flush_done;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic hash_en;
		logic mod_en;
		logic probe_init;
		logic probe_en;
		logic clear_en;
		logic out_load;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic mod_done;
		logic probe_stop;
		logic clear_last;
	} dp_sts_t;

endpackage

### sv/gkc_req_if.sv
// Request channel: valid/ready handshake carrying one cache request.
interface gkc_req_if import gkc_pkg::*; ();
	logic valid;
	logic ready;
	req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### sv/gkc_rsp_if.sv
// Response channel: valid/ready handshake carrying one cache result.
interface gkc_rsp_if import gkc_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### sv/gkc_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
module gkc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

### sv/gkc_ctrl.sv
// Sequencing FSM: clear pass, hash, modulo, probe and response hand-off.
module gkc_ctrl import gkc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	input  logic    req_action,
	output logic    req_ready,
	output logic    rsp_valid,
	input  logic    rsp_ready,
	output dp_cmd_t cmd,
	input  dp_sts_t sts
);
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_MOD,
		ST_PROBE,
		ST_RESP
	} state_t;

	state_t state_q;
	logic   flush_q;
	logic   rsp_vld_q;
	logic   out_free;

	assign out_free  = !rsp_vld_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_vld_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_CLEAR: cmd.clear_en = 1'b1;
			ST_IDLE:  cmd.load = req_valid;
			ST_HASH:  cmd.hash_en = 1'b1;
			ST_MOD: begin
				cmd.mod_en     = 1'b1;
				cmd.probe_init = sts.mod_done;
			end
			ST_PROBE: cmd.probe_en = 1'b1;
			ST_RESP:  cmd.out_load = out_free;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			flush_q   <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			// a new result replaces the one taken at this edge
			if (state_q == ST_RESP && out_free) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (sts.clear_last) begin
						state_q <= flush_q ? ST_RESP : ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						flush_q <= (req_action == ACT_FLUSH);
						state_q <= (req_action == ACT_FLUSH) ? ST_CLEAR : ST_HASH;
					end
				end
				ST_HASH: state_q <= ST_MOD;
				ST_MOD: begin
					if (sts.mod_done) begin
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					if (sts.probe_stop) begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

### sv/gkc_datapath.sv
// Key hash, start-slot reduction, probe walk over the slot RAM, result regs.
module gkc_datapath import gkc_pkg::*; #(
	parameter int SLOT_COUNT = 256
) (
	input  logic    clk,
	input  logic    arst_n,
	input  req_t    req,
	input  dp_cmd_t cmd,
	output dp_sts_t sts,
	output rsp_t    rsp
);
	localparam int  AW    = $clog2(SLOT_COUNT);
	localparam bit  IS_P2 = (SLOT_COUNT == (1 << AW));
	localparam logic [AW-1:0] LAST_SLOT = AW'(SLOT_COUNT - 1);

	function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] a);
		return (a == LAST_SLOT) ? '0 : AW'(a + 1'b1);
	endfunction

	function automatic logic [SLOT_IDX_W-1:0] low_idx(input logic [AW-1:0] a);
		logic [AW+SLOT_IDX_W-1:0] wide;
		wide = {{SLOT_IDX_W{1'b0}}, a};
		return wide[SLOT_IDX_W-1:0];
	endfunction

	// key and hash products
	logic [CP_W-1:0]   cp_q;
	logic [PX_W-1:0]   px_q;
	logic [HASH_W-1:0] prod_cp_q;
	logic [HASH_W-1:0] prod_px_q;

	// probe state
	logic [AW-1:0] start_q;
	logic [AW-1:0] iss_q;
	logic [AW-1:0] chk_q;
	logic [AW-1:0] seen_q;
	logic [AW-1:0] clr_q;
	logic          dvld_q;

	// pending result and output register
	logic                  res_hit_q;
	logic [SLOT_IDX_W-1:0] res_slot_q;
	logic                  res_evict_q;
	logic                  res_flush_q;
	rsp_t                  out_q;

	logic [AW-1:0]      start_w;
	logic               mod_done_w;
	logic [ENTRY_W-1:0] rdata;
	logic               e_vld;
	logic               is_free;
	logic               is_hit;
	logic               is_full;
	logic               stop;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cp_q        <= req.code_point;
			px_q        <= req.pixel_size;
			prod_cp_q   <= HASH_W'(HASH_W'(req.code_point) * HASH_MUL_CP);
			prod_px_q   <= HASH_W'(HASH_W'(req.pixel_size) * HASH_MUL_PX);
			res_hit_q   <= 1'b0;
			res_slot_q  <= '0;
			res_evict_q <= 1'b0;
			res_flush_q <= (req.action == ACT_FLUSH);
		end
		if (stop) begin
			res_hit_q   <= is_hit;
			res_slot_q  <= low_idx((is_hit || is_free) ? chk_q : start_q);
			res_evict_q <= is_full;
		end
		if (cmd.probe_init) begin
			start_q <= start_w;
		end
		if (cmd.out_load) begin
			out_q <= '{hit: res_hit_q, slot_index: res_slot_q,
				evicted: res_evict_q, flush_done: res_flush_q};
		end
	end

	// start slot = hash mod SLOT_COUNT
	generate
		if (IS_P2) begin : g_mask
			logic [HASH_W-1:0] hash_q;

			always_ff @(posedge clk) begin
				if (cmd.hash_en) begin
					hash_q <= prod_cp_q ^ prod_px_q;
				end
			end

			assign start_w    = hash_q[AW-1:0];
			assign mod_done_w = 1'b1;
		end else begin : g_rem
			// reciprocal multiply: (hash * RECIP) >> 32 falls short of the quotient
			// by at most one, so a single compare-subtract finishes the remainder
			localparam logic [HASH_W-1:0] RECIP =
				HASH_W'((64'd1 << HASH_W) / SLOT_COUNT);
			localparam logic [HASH_W-1:0] SLOTS = HASH_W'(SLOT_COUNT);
			localparam int STEPS = 3;
			localparam int CNT_W = 2;

			logic [HASH_W-1:0]   hash_q;
			logic [2*HASH_W-1:0] prod_q;
			logic [HASH_W-1:0]   qs_q;
			logic [HASH_W-1:0]   diff;
			logic [AW-1:0]       rem_q;
			logic [CNT_W-1:0]    cnt_q;

			assign diff = hash_q - qs_q;

			always_ff @(posedge clk) begin
				if (cmd.hash_en) begin
					hash_q <= prod_cp_q ^ prod_px_q;
				end
				prod_q <= (2*HASH_W)'(hash_q) * (2*HASH_W)'(RECIP);
				qs_q   <= HASH_W'(prod_q[2*HASH_W-1:HASH_W] * SLOTS);
				rem_q  <= (diff >= SLOTS) ? AW'(diff - SLOTS) : AW'(diff);
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					cnt_q <= '0;
				end else if (cmd.hash_en) begin
					cnt_q <= CNT_W'(STEPS);
				end else if (cmd.mod_en && cnt_q != '0) begin
					cnt_q <= CNT_W'(cnt_q - 1'b1);
				end
			end

			assign start_w    = rem_q;
			assign mod_done_w = (cnt_q == '0);
		end
	endgenerate

	// entry layout {valid, code_point, pixel_size}
	assign e_vld   = rdata[ENTRY_W-1];
	assign is_free = !e_vld;
	assign is_hit  = e_vld && (rdata[ENTRY_W-2:PX_W] == cp_q) && (rdata[PX_W-1:0] == px_q);
	assign is_full = e_vld && !is_hit && (seen_q == LAST_SLOT);
	assign stop    = cmd.probe_en && dvld_q && (is_free || is_hit || is_full);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			dvld_q <= 1'b0;
			iss_q  <= '0;
			chk_q  <= '0;
			seen_q <= '0;
		end else begin
			if (cmd.clear_en) begin
				clr_q <= next_slot(clr_q);
			end
			if (cmd.probe_init) begin
				iss_q  <= start_w;
				dvld_q <= 1'b0;
				seen_q <= '0;
			end else if (cmd.probe_en) begin
				// reads run one slot ahead of the compare
				iss_q  <= next_slot(iss_q);
				chk_q  <= iss_q;
				dvld_q <= 1'b1;
				if (dvld_q) begin
					seen_q <= AW'(seen_q + 1'b1);
				end
			end
		end
	end

	assign ram_we    = cmd.clear_en || (stop && !is_hit);
	assign ram_waddr = cmd.clear_en ? clr_q : (is_free ? chk_q : start_q);
	assign ram_wdata = cmd.clear_en ? '0 : {1'b1, cp_q, px_q};

	gkc_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (SLOT_COUNT)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (iss_q),
		.rdata (rdata)
	);

	assign sts.mod_done   = mod_done_w;
	assign sts.probe_stop = stop;
	assign sts.clear_last = (clr_q == LAST_SLOT);
	assign rsp            = out_q;
endmodule

### sv/glyph_key_cache_linear_probe_core.sv
// Top level of the glyph key cache tag store (hash table, linear probing).
//
//  channel | dir | payload                                 | handshake
//  --------+-----+-----------------------------------------+------------
//  req     | in  | action, code_point, pixel_size          | valid/ready
//  rsp     | out | hit, slot_index, evicted, flush_done    | valid/ready
//
// A lookup request passes from accept to result register through the hash, the
// start slot, the RAM read and the probe of each slot, then the result load;
// the probe walk reads one slot per cycle from the slot RAM port.
// With a non power-of-two SLOT_COUNT the start-slot reduction is a reciprocal
// multiply in three register stages. A flush request runs a RAM clear pass,
// one slot per cycle, then the result load. After reset a clear pass over
// every slot runs before the first request is taken. One request is in
// flight at a time; the result register lets the next request be taken
// while rsp is stalled.
module glyph_key_cache_linear_probe_core import gkc_pkg::*; #(
	parameter int SLOT_COUNT = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	gkc_req_if.sink      req,
	gkc_rsp_if.source    rsp
);
	dp_cmd_t cmd;
	dp_sts_t sts;

	// FSM: owns handshake and sequencing
	gkc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_action (req.payload.action),
		.req_ready  (req.ready),
		.rsp_valid  (rsp.valid),
		.rsp_ready  (rsp.ready),
		.cmd        (cmd),
		.sts        (sts)
	);

	// hash, probe walk, slot RAM and result registers
	gkc_datapath #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.payload),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp.payload)
	);

`ifndef SYNTHESIS
	// a flush result carries no lookup outcome
	a_flush_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.payload.flush_done |-> !rsp.payload.hit && !rsp.payload.evicted)
		else $error("flush result with hit or evicted set");

	// a hit never evicts
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.payload.hit && rsp.payload.evicted))
		else $error("hit and evicted both set");

	// one request in flight: ready drops after an accept
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while another is in flight");
`endif
endmodule
